// ===== sv/tpwr_pkg.sv =====
// Package for the touch pulse width recorder: widths, codes, shared types and helpers.
// Used by the interfaces and every module of the block; depends on nothing else.
package tpwr_pkg;

    // Millisecond counter width and its saturation value.
    localparam int TIME_W   = 20;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Field widths of the configuration and of the result words.
    localparam int TICK_W   = 10;
    localparam int SEG_W    = 8;
    localparam int TICKS_W  = 16;
    localparam int REASON_W = 2;

    // Divider: dividend holds a duration plus half a tick.
    localparam int DIV_W     = TIME_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Job queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // APB register map.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam logic [2:0] REG_ACTIVE_HIGH = 3'd0;
    localparam logic [2:0] REG_TICK_MS     = 3'd1;
    localparam logic [2:0] REG_MAX_RECORD  = 3'd2;
    localparam logic [2:0] REG_END_GAP     = 3'd3;
    localparam logic [2:0] REG_MAX_SEG     = 3'd4;

    // Input operation codes.
    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Result word kinds.
    localparam logic KIND_SEG  = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Stop reasons.
    localparam logic [REASON_W-1:0] STOP_MAX_RECORD = 2'd0;
    localparam logic [REASON_W-1:0] STOP_END_GAP    = 2'd1;
    localparam logic [REASON_W-1:0] STOP_IDLE       = 2'd2;
    localparam logic [REASON_W-1:0] STOP_MAX_SEG    = 2'd3;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic              active_high;
        logic [TICK_W-1:0] tick_ms;
        logic [TIME_W-1:0] max_record_ms;
        logic [TIME_W-1:0] end_gap_ms;
        logic [SEG_W-1:0]  slot_limit;
    } cfg_t;

    // One queue entry: an optional segment and an optional done word.
    typedef struct packed {
        logic                has_seg;
        logic                seg_level;
        logic [TIME_W-1:0]   dur;
        logic                has_done;
        logic [SEG_W-1:0]    seg_count;
        logic [REASON_W-1:0] stop_reason;
    } job_t;

    // Saturating millisecond increment.
    function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
        sat_inc = (v == TIME_MAX) ? TIME_MAX : v + TIME_W'(1);
    endfunction

endpackage

// ===== sv/tpwr_ifs.sv =====
// Valid/ready channel interfaces for the input and result words of the recorder.
// Depends on tpwr_pkg for field widths.
interface tpwr_in_if;
    import tpwr_pkg::*;

    logic valid;
    logic ready;
    logic op;
    logic pin_level;

    modport source (output valid, output op, output pin_level, input ready);
    modport sink (input valid, input op, input pin_level, output ready);
endinterface

interface tpwr_out_if;
    import tpwr_pkg::*;

    logic                valid;
    logic                ready;
    logic                kind;
    logic                seg_level;
    logic [TICKS_W-1:0]  seg_ticks;
    logic [SEG_W-1:0]    seg_count;
    logic [REASON_W-1:0] stop_reason;
    logic                last;

    modport source (output valid, output kind, output seg_level, output seg_ticks,
                    output seg_count, output stop_reason, output last, input ready);
    modport sink (input valid, input kind, input seg_level, input seg_ticks,
                  input seg_count, input stop_reason, input last, output ready);
endinterface

// ===== sv/touch_pulse_width_recorder.sv =====
// Touch pulse width recorder. A start word latches the touched level; each sample word
// is one millisecond. Samples that close no segment and end nothing are taken every
// cycle while the two-entry job queue has room. A sample that closes a segment goes
// through the back end in order: the job is taken, 21 steps of the one-bit-per-cycle
// restoring divider round the duration to ticks, and the result register is loaded;
// a done word is loaded after it, and a stalled receiver holds the back end until
// the result register is free. The queue lets the front keep taking samples
// while the divider works. Configuration sits on an APB port at byte addresses
// 0, 4, 8, 12 and 16: active_high, tick_ms, max_record_ms, end_gap_ms and the segment
// slot limit.
// Depends on tpwr_pkg, tpwr_ifs, tpwr_front, tpwr_queue and tpwr_back.
module touch_pulse_width_recorder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpwr_pkg::ADDR_W-1:0]   paddr,
    input  logic [tpwr_pkg::DATA_W-1:0]   pwdata,
    output logic [tpwr_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    tpwr_in_if.sink                       in_word,
    tpwr_out_if.source                    out_word
);
    import tpwr_pkg::*;

    logic              active_high_reg;
    logic [TICK_W-1:0] tick_ms_reg;
    logic [TIME_W-1:0] max_record_reg;
    logic [TIME_W-1:0] end_gap_reg;
    logic [SEG_W-1:0]  max_seg_reg;

    logic       cfg_wr;
    logic [2:0] reg_idx;
    cfg_t       cfg;

    logic q_full, q_empty, q_push, q_pop;
    job_t q_in_job, q_out_job;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_high_reg <= 1'b1;
            tick_ms_reg     <= TICK_W'(10);
            max_record_reg  <= TIME_W'(10000);
            end_gap_reg     <= TIME_W'(1500);
            max_seg_reg     <= SEG_W'(64);
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_ACTIVE_HIGH: active_high_reg <= pwdata[0];
                REG_TICK_MS:     tick_ms_reg     <= pwdata[TICK_W-1:0];
                REG_MAX_RECORD:  max_record_reg  <= pwdata[TIME_W-1:0];
                REG_END_GAP:     end_gap_reg     <= pwdata[TIME_W-1:0];
                REG_MAX_SEG:     max_seg_reg     <= pwdata[SEG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (reg_idx)
            REG_ACTIVE_HIGH: prdata = DATA_W'(active_high_reg);
            REG_TICK_MS:     prdata = DATA_W'(tick_ms_reg);
            REG_MAX_RECORD:  prdata = DATA_W'(max_record_reg);
            REG_END_GAP:     prdata = DATA_W'(end_gap_reg);
            REG_MAX_SEG:     prdata = DATA_W'(max_seg_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.active_high   = active_high_reg;
    assign cfg.tick_ms       = tick_ms_reg;
    assign cfg.max_record_ms = max_record_reg;
    assign cfg.end_gap_ms    = end_gap_reg;
    assign cfg.slot_limit    = max_seg_reg;

    tpwr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .in_word (in_word),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_job   (q_in_job)
    );

    tpwr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_in_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (q_out_job),
        .empty    (q_empty)
    );

    tpwr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_job    (q_out_job),
        .out_word (out_word)
    );

endmodule

// ===== sv/tpwr_front.sv =====
// Front end: accepts start and sample words, keeps the recording state and
// classifies each sample into a queue job. Depends on tpwr_pkg and tpwr_in_if.
module tpwr_front (
    input  logic          clk,
    input  logic          rst_n,
    input  tpwr_pkg::cfg_t cfg,
    tpwr_in_if.sink       in_word,
    input  logic          q_full,
    output logic          q_push,
    output tpwr_pkg::job_t q_job
);
    import tpwr_pkg::*;

    logic              recording_reg, recording_next;
    logic              level_reg, level_next;
    logic [TIME_W-1:0] seg_ms_reg, seg_ms_next;
    logic [TIME_W-1:0] rec_ms_reg, rec_ms_next;
    logic [TIME_W-1:0] gap_ms_reg, gap_ms_next;
    logic              touch_reg, touch_next;
    logic [SEG_W-1:0]  slots_reg, slots_next;
    logic              lead_reg, lead_next;

    logic              accept;
    logic              now;
    logic [TIME_W-1:0] rec_inc, seg_inc, gap_inc;
    logic              hit_rec, changed, gap_hit, idle_hit, do_seg;

    assign in_word.ready = !q_full;
    assign accept = in_word.valid && in_word.ready;

    // Per-sample update in the order of checks: max record, touch, change,
    // end gap, initial idle, slots.
    always_comb
    begin
        recording_next = recording_reg;
        level_next     = level_reg;
        seg_ms_next    = seg_ms_reg;
        rec_ms_next    = rec_ms_reg;
        gap_ms_next    = gap_ms_reg;
        touch_next     = touch_reg;
        slots_next     = slots_reg;
        lead_next      = lead_reg;
        q_push         = 1'b0;
        q_job          = '0;

        now      = cfg.active_high ? in_word.pin_level : ~in_word.pin_level;
        rec_inc  = sat_inc(rec_ms_reg);
        seg_inc  = sat_inc(seg_ms_reg);
        gap_inc  = sat_inc(gap_ms_reg);
        hit_rec  = 1'b0;
        changed  = 1'b0;
        gap_hit  = 1'b0;
        idle_hit = 1'b0;
        do_seg   = 1'b0;

        if (accept && in_word.op == OP_START)
        begin
            recording_next = 1'b1;
            level_next     = now;
            seg_ms_next    = '0;
            rec_ms_next    = '0;
            gap_ms_next    = '0;
            touch_next     = now;
            slots_next     = '0;
            lead_next      = 1'b0;
        end
        else if (accept && recording_reg)
        begin
            rec_ms_next = rec_inc;
            seg_ms_next = seg_inc;
            gap_ms_next = gap_inc;
            hit_rec     = (rec_inc >= cfg.max_record_ms);

            if (!hit_rec)
            begin
                touch_next = touch_reg | now;
                if (now)
                begin
                    gap_ms_next = '0;
                end
                changed = (now != level_reg);
                if (changed)
                begin
                    level_next  = now;
                    seg_ms_next = '0;
                end
                gap_hit  = !now && touch_next && (gap_ms_next >= cfg.end_gap_ms);
                idle_hit = !now && !touch_next && (seg_ms_next >= cfg.end_gap_ms);
            end

            // At most one segment closes per sample, always the old level.
            do_seg = hit_rec || changed || gap_hit;
            if (do_seg && (slots_reg < cfg.slot_limit))
            begin
                slots_next = slots_reg + SEG_W'(1);
                if (slots_reg == '0 && !level_reg)
                begin
                    lead_next = 1'b1;
                end
                else
                begin
                    q_job.has_seg   = 1'b1;
                    q_job.seg_level = level_reg;
                    q_job.dur       = seg_inc;
                end
            end

            // Stop checks.
            if (hit_rec)
            begin
                q_job.has_done    = 1'b1;
                q_job.stop_reason = STOP_MAX_RECORD;
            end
            else if (gap_hit)
            begin
                q_job.has_done    = 1'b1;
                q_job.stop_reason = STOP_END_GAP;
            end
            else if (idle_hit)
            begin
                q_job.has_done    = 1'b1;
                q_job.stop_reason = STOP_IDLE;
            end
            else if (slots_next >= cfg.slot_limit)
            begin
                q_job.has_done    = 1'b1;
                q_job.stop_reason = STOP_MAX_SEG;
            end

            if (q_job.has_done)
            begin
                recording_next = 1'b0;
                if (q_job.stop_reason != STOP_IDLE)
                begin
                    q_job.seg_count = slots_next - SEG_W'(lead_next);
                end
            end
            q_push = q_job.has_seg || q_job.has_done;
        end
    end

    // Recording state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recording_reg <= 1'b0;
            level_reg     <= 1'b0;
            seg_ms_reg    <= '0;
            rec_ms_reg    <= '0;
            gap_ms_reg    <= '0;
            touch_reg     <= 1'b0;
            slots_reg     <= '0;
            lead_reg      <= 1'b0;
        end
        else
        begin
            recording_reg <= recording_next;
            level_reg     <= level_next;
            seg_ms_reg    <= seg_ms_next;
            rec_ms_reg    <= rec_ms_next;
            gap_ms_reg    <= gap_ms_next;
            touch_reg     <= touch_next;
            slots_reg     <= slots_next;
            lead_reg      <= lead_next;
        end
    end

    // A dropped leading idle segment always occupies a slot.
    a_lead_uses_slot: assert property (@(posedge clk) disable iff (!rst_n)
        lead_reg |-> slots_reg != '0)
        else $error("leading idle marked without a used slot");

    // Only a sample taken while recording can produce a job.
    a_push_recording: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> recording_reg && in_word.op == OP_SAMPLE)
        else $error("job pushed outside a recording");

endmodule

// ===== sv/tpwr_queue.sv =====
// Two-entry job queue between the front end and the divider back end.
// Depends on tpwr_pkg for the job type and depth.
module tpwr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tpwr_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output tpwr_pkg::job_t pop_job,
    output logic           empty
);
    import tpwr_pkg::*;

    job_t            mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_CW-1:0] count_reg;

    assign full    = (count_reg == Q_CW'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = mem[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + Q_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + Q_AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + Q_CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - Q_CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop) && !(pop && empty))
        else $error("queue overflow or underflow");

endmodule

// ===== sv/tpwr_back.sv =====
// Back end: takes jobs from the queue, converts segment durations to ticks with a
// restoring divider and drives the registered result channel. Depends on tpwr_pkg.
module tpwr_back (
    input  logic           clk,
    input  logic           rst_n,
    input  tpwr_pkg::cfg_t cfg,
    input  logic           q_empty,
    output logic           q_pop,
    input  tpwr_pkg::job_t q_job,
    tpwr_out_if.source     out_word
);
    import tpwr_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SEG  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]           state_reg, state_next;
    job_t                 job_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [TICK_W-1:0]    rem_reg;
    logic [DIV_CNT_W-1:0] step_reg;

    logic                 out_valid_reg;
    logic                 kind_reg;
    logic                 level_reg;
    logic [TICKS_W-1:0]   ticks_reg;
    logic [SEG_W-1:0]     count_reg;
    logic [REASON_W-1:0]  reason_reg;

    logic [TICK_W-1:0]    divisor;
    logic [DIV_W-1:0]     dividend;
    logic [TICK_W:0]      trial;
    logic [TICK_W:0]      diff;
    logic                 ge;
    logic                 load_ok;
    logic [TICKS_W-1:0]   ticks_sat;

    // Divisor, rounded dividend and one restoring step.
    assign divisor  = (cfg.tick_ms == '0) ? TICK_W'(1) : cfg.tick_ms;
    assign dividend = DIV_W'(q_job.dur) + DIV_W'(divisor >> 1);
    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign diff     = trial - {1'b0, divisor};
    assign ge       = (trial >= {1'b0, divisor});

    // Quotient clamped to 1 .. 65535.
    always_comb
    begin
        if (quo_reg[DIV_W-1:TICKS_W] != '0)
        begin
            ticks_sat = {TICKS_W{1'b1}};
        end
        else if (quo_reg == '0)
        begin
            ticks_sat = TICKS_W'(1);
        end
        else
        begin
            ticks_sat = quo_reg[TICKS_W-1:0];
        end
    end

    assign load_ok = !out_valid_reg || out_word.ready;
    assign q_pop   = (state_reg == ST_IDLE) && !q_empty;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = q_job.has_seg ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = ST_SEG;
                end
            end
            ST_SEG:
            begin
                if (load_ok)
                begin
                    state_next = job_reg.has_done ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (load_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_SEG || state_reg == ST_DONE) && load_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_word.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Job, divider and result payload registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg  <= q_job;
            quo_reg  <= dividend;
            rem_reg  <= '0;
            step_reg <= DIV_CNT_W'(DIV_W - 1);
        end
        else if (state_reg == ST_DIV)
        begin
            quo_reg  <= {quo_reg[DIV_W-2:0], ge};
            rem_reg  <= ge ? diff[TICK_W-1:0] : trial[TICK_W-1:0];
            step_reg <= step_reg - DIV_CNT_W'(1);
        end

        if (state_reg == ST_SEG && load_ok)
        begin
            kind_reg   <= KIND_SEG;
            level_reg  <= job_reg.seg_level;
            ticks_reg  <= ticks_sat;
            count_reg  <= '0;
            reason_reg <= '0;
        end
        else if (state_reg == ST_DONE && load_ok)
        begin
            kind_reg   <= KIND_DONE;
            level_reg  <= 1'b0;
            ticks_reg  <= '0;
            count_reg  <= job_reg.seg_count;
            reason_reg <= job_reg.stop_reason;
        end
    end

    assign out_word.valid       = out_valid_reg;
    assign out_word.kind        = kind_reg;
    assign out_word.seg_level   = level_reg;
    assign out_word.seg_ticks   = ticks_reg;
    assign out_word.seg_count   = count_reg;
    assign out_word.stop_reason = reason_reg;
    assign out_word.last        = kind_reg;

    // The partial remainder stays below the divisor through the division.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < divisor)
        else $error("divider remainder out of range");

    // Segment words always carry a nonzero tick count.
    a_seg_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_SEG |-> ticks_reg != '0)
        else $error("segment word with zero ticks");

    // A segment is only emitted for a job that carries one.
    a_seg_job: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEG |-> job_reg.has_seg)
        else $error("segment state without a segment job");

endmodule
